FILE: rtl/core/goge_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// goge_pkg
// Shared types, widths and constants of the Gaussian orbital grid evaluator.
// ----------------------------------------------------------------------------
package goge_pkg;

   localparam int GRID_DIM_DEFAULT = 1024;

   localparam int GRID_W   = 10;
   localparam int SPACE_W  = 24;
   localparam int COORD_W  = 32;
   localparam int INVR_W   = 24;
   localparam int CNT_W    = 4;
   localparam int VALUE_W  = 32;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 3;

   localparam int GH_W     = GRID_W + SPACE_W;
   localparam int T_W      = INVR_W + 3;
   localparam int ALPHA_W  = 2 * T_W - 20;
   localparam int SQ_W     = 47;
   localparam int CROSS_W  = 48;
   localparam int R2_W     = 48;
   localparam int P_W      = 50;
   localparam int MAG_W    = 48;
   localparam int Y_W      = 29;
   localparam int TERM_W   = 31;
   localparam int EX_W     = 31;
   localparam int NTERMS   = 10;
   localparam int NSQUARE  = 5;

   // start edge to result strobe, in clock edges
   localparam int LATENCY  = 4 + 2 + 2 * NTERMS + NSQUARE + 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SPACING_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACING_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACING_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Z  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_RADIUS = 3'd6;

   localparam logic [INVR_W-1:0] INV_RADIUS_RESET = 24'h100000;

   localparam logic [3:0] KIND_S     = 4'd0;
   localparam logic [3:0] KIND_PX    = 4'd1;
   localparam logic [3:0] KIND_PY    = 4'd2;
   localparam logic [3:0] KIND_PZ    = 4'd3;
   localparam logic [3:0] KIND_DXY   = 4'd4;
   localparam logic [3:0] KIND_DXZ   = 4'd5;
   localparam logic [3:0] KIND_DYZ   = 4'd6;
   localparam logic [3:0] KIND_DX2Y2 = 4'd7;
   localparam logic [3:0] KIND_DZ2   = 4'd8;
   localparam logic [3:0] KIND_SS    = 4'd9;
   localparam logic [3:0] KIND_S1    = 4'd10;
   localparam logic [3:0] KIND_PX1   = 4'd11;
   localparam logic [3:0] KIND_PY1   = 4'd12;
   localparam logic [3:0] KIND_PZ1   = 4'd13;

   // exact floor(x / n) for x < 2^30 as (x * magic) >> shift
   localparam logic [30:0] DIV_MAGIC [1:NTERMS] = '{
      31'd1073741824, 31'd1073741824, 31'd1431655766, 31'd1073741824,
      31'd1717986919, 31'd1431655766, 31'd1227133514, 31'd1073741824,
      31'd1908874354, 31'd1717986919
   };
   localparam int DIV_SHIFT [1:NTERMS] = '{30, 31, 32, 32, 33, 33, 33, 33, 34, 34};

   typedef struct packed {
      logic [SPACE_W-1:0]        spacing_x;
      logic [SPACE_W-1:0]        spacing_y;
      logic [SPACE_W-1:0]        spacing_z;
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic [INVR_W-1:0]         inv_radius;
   } cfg_type;

   typedef struct packed {
      logic last;
      logic err;
   } tag_type;

   typedef struct packed {
      logic             last;
      logic             err;
      logic             zero;
      logic             neg;
      logic [MAG_W-1:0] mag;
   } carry_type;

endpackage

FILE: rtl/core/goge_geom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// goge_geom
// Offsets from the centre, squares, cross product, r2, polynomial and alpha
// in four register stages.
// ----------------------------------------------------------------------------
module goge_geom #(
   parameter int GRID_DIM = goge_pkg::GRID_DIM_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  goge_pkg::cfg_type                    cfg,
   input  logic                                 in_valid,
   input  logic [goge_pkg::GRID_W-1:0]          grid_x,
   input  logic [goge_pkg::GRID_W-1:0]          grid_y,
   input  logic [goge_pkg::GRID_W-1:0]          grid_z,
   input  logic [goge_pkg::CNT_W-1:0]           orbital_count,
   input  logic [goge_pkg::CNT_W-1:0]           orbital_slot,
   input  logic                                 last_point,
   output logic                                 out_valid,
   output goge_pkg::tag_type                    out_tag,
   output logic [goge_pkg::R2_W-1:0]            out_r2,
   output logic [goge_pkg::ALPHA_W-1:0]         out_alpha,
   output logic signed [goge_pkg::P_W-1:0]      out_p
);
   import goge_pkg::*;

   localparam int GD_W = 17;
   localparam logic [GD_W-1:0] GRID_LIM = GD_W'(GRID_DIM);
   localparam logic [GD_W-1:0] GRID_MAX = GD_W'(GRID_DIM - 1);

   function automatic logic [GRID_W-1:0] clamp(input logic [GRID_W-1:0] g);
      if (GD_W'(g) >= GRID_LIM) return GRID_MAX[GRID_W-1:0];
      return g;
   endfunction

   function automatic logic [3:0] map_kind(input logic [3:0] cnt, input logic [3:0] slot);
      logic [3:0] k;
      k = slot;
      if (cnt < 4'd4) begin
         if (slot == 4'd1) k = KIND_SS;
         if (slot == 4'd2) k = KIND_S1;
      end
      if (cnt < 4'd7) begin
         if (slot == 4'd4) k = KIND_SS;
         if (slot == 4'd5) k = KIND_S1;
      end
      if (cnt == 4'd7) begin
         if (slot == 4'd4) k = KIND_PX1;
         if (slot == 4'd5) k = KIND_PY1;
         if (slot == 4'd6) k = KIND_PZ1;
      end
      if (cnt == 4'd8) begin
         if (slot == 4'd4) k = KIND_S1;
         if (slot == 4'd5) k = KIND_PX1;
         if (slot == 4'd6) k = KIND_PY1;
         if (slot == 4'd7) k = KIND_PZ1;
      end
      return k;
   endfunction

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [GH_W+1:0] v);
      if (!v[GH_W+1] && (v[GH_W:COORD_W-1] != '0)) return {1'b0, {(COORD_W-1){1'b1}}};
      if (v[GH_W+1] && (v[GH_W:COORD_W-1] != '1)) return {1'b1, {(COORD_W-1){1'b0}}};
      return v[COORD_W-1:0];
   endfunction

   // stage 1
   logic                 v1_ff;
   tag_type              tag1_ff;
   logic [3:0]           kind1_ff, kind1_in;
   logic [GH_W-1:0]      ghx1_ff, ghy1_ff, ghz1_ff;
   logic [T_W-1:0]       t1_ff, t1_in;

   assign kind1_in = map_kind(orbital_count, orbital_slot);
   assign t1_in = (kind1_in >= KIND_S1) ?
      ({cfg.inv_radius, 3'b000} - {3'b000, cfg.inv_radius}) :
      ({1'b0, cfg.inv_radius, 2'b00} + {2'b00, cfg.inv_radius, 1'b0});

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= in_valid;
      tag1_ff.last <= last_point;
      tag1_ff.err  <= (kind1_in > KIND_PZ1);
      kind1_ff <= kind1_in;
      ghx1_ff  <= GH_W'(clamp(grid_x)) * GH_W'(cfg.spacing_x);
      ghy1_ff  <= GH_W'(clamp(grid_y)) * GH_W'(cfg.spacing_y);
      ghz1_ff  <= GH_W'(clamp(grid_z)) * GH_W'(cfg.spacing_z);
      t1_ff    <= t1_in;
   end

   // stage 2
   logic                      v2_ff;
   tag_type                   tag2_ff;
   logic [3:0]                kind2_ff;
   logic signed [COORD_W-1:0] x2_ff, y2_ff, z2_ff;
   logic [ALPHA_W-1:0]        alpha2_ff;
   logic [2*T_W-1:0]          tt2_in;
   logic signed [GH_W+1:0]    dx2_in, dy2_in, dz2_in;

   assign dx2_in = $signed({2'b00, ghx1_ff}) - (GH_W+2)'(cfg.center_x);
   assign dy2_in = $signed({2'b00, ghy1_ff}) - (GH_W+2)'(cfg.center_y);
   assign dz2_in = $signed({2'b00, ghz1_ff}) - (GH_W+2)'(cfg.center_z);
   assign tt2_in = (2*T_W)'(t1_ff) * (2*T_W)'(t1_ff);

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      tag2_ff   <= tag1_ff;
      kind2_ff  <= kind1_ff;
      x2_ff     <= sat32(dx2_in);
      y2_ff     <= sat32(dy2_in);
      z2_ff     <= sat32(dz2_in);
      alpha2_ff <= tt2_in[2*T_W-1:20];
   end

   // stage 3
   logic                      v3_ff;
   tag_type                   tag3_ff;
   logic [3:0]                kind3_ff;
   logic signed [COORD_W-1:0] x3_ff, y3_ff, z3_ff;
   logic [ALPHA_W-1:0]        alpha3_ff;
   logic [SQ_W-1:0]           sqx3_ff, sqy3_ff, sqz3_ff;
   logic signed [CROSS_W-1:0] cross3_ff;
   logic signed [63:0]        xx3_in, yy3_in, zz3_in, ab3_in;
   logic signed [COORD_W-1:0] ca3_in, cb3_in;

   always_comb begin
      unique case (kind2_ff)
         KIND_DXY: begin
            ca3_in = x2_ff;
            cb3_in = y2_ff;
         end
         KIND_DXZ: begin
            ca3_in = x2_ff;
            cb3_in = z2_ff;
         end
         default: begin
            ca3_in = y2_ff;
            cb3_in = z2_ff;
         end
      endcase
   end

   assign xx3_in = 64'(x2_ff) * 64'(x2_ff);
   assign yy3_in = 64'(y2_ff) * 64'(y2_ff);
   assign zz3_in = 64'(z2_ff) * 64'(z2_ff);
   assign ab3_in = 64'(ca3_in) * 64'(cb3_in);

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      tag3_ff   <= tag2_ff;
      kind3_ff  <= kind2_ff;
      x3_ff     <= x2_ff;
      y3_ff     <= y2_ff;
      z3_ff     <= z2_ff;
      alpha3_ff <= alpha2_ff;
      sqx3_ff   <= xx3_in[62:16];
      sqy3_ff   <= yy3_in[62:16];
      sqz3_ff   <= zz3_in[62:16];
      cross3_ff <= ab3_in[63:16];
   end

   // stage 4
   logic                  v4_ff;
   tag_type               tag4_ff;
   logic [R2_W-1:0]       r24_ff, r24_in;
   logic [ALPHA_W-1:0]    alpha4_ff;
   logic signed [P_W-1:0] p4_ff, p4_in;

   assign r24_in = R2_W'(sqx3_ff) + R2_W'(sqy3_ff) + R2_W'(sqz3_ff);

   always_comb begin
      unique case (kind3_ff)
         KIND_PX, KIND_PX1: p4_in = P_W'(x3_ff);
         KIND_PY, KIND_PY1: p4_in = P_W'(y3_ff);
         KIND_PZ, KIND_PZ1: p4_in = P_W'(z3_ff);
         KIND_DXY, KIND_DXZ, KIND_DYZ: p4_in = P_W'(cross3_ff);
         KIND_DX2Y2: p4_in = $signed({3'b000, sqx3_ff}) - $signed({3'b000, sqy3_ff});
         KIND_DZ2: p4_in = $signed({3'b000, sqx3_ff}) + $signed({3'b000, sqy3_ff})
                           - $signed({2'b00, sqz3_ff, 1'b0});
         KIND_SS: p4_in = $signed({2'b00, r24_in});
         default: p4_in = P_W'(65536);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else v4_ff <= v3_ff;
      tag4_ff   <= tag3_ff;
      r24_ff    <= r24_in;
      alpha4_ff <= alpha3_ff;
      p4_ff     <= p4_in;
   end

   assign out_valid = v4_ff;
   assign out_tag   = tag4_ff;
   assign out_r2    = r24_ff;
   assign out_alpha = alpha4_ff;
   assign out_p     = p4_ff;

endmodule

FILE: rtl/core/goge_expo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// goge_expo
// Exponent argument alpha*r2 in two split products, range check and
// polynomial magnitude, over two register stages.
// ----------------------------------------------------------------------------
module goge_expo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  goge_pkg::tag_type                 in_tag,
   input  logic [goge_pkg::R2_W-1:0]         in_r2,
   input  logic [goge_pkg::ALPHA_W-1:0]      in_alpha,
   input  logic signed [goge_pkg::P_W-1:0]   in_p,
   output logic                              out_valid,
   output goge_pkg::carry_type               out_carry,
   output logic [goge_pkg::Y_W-1:0]          out_y
);
   import goge_pkg::*;

   localparam int A_W = ALPHA_W + 20;
   localparam int S_W = A_W + 21;

   logic                  v5_ff;
   carry_type             c5_ff;
   logic                  big5_ff;
   logic [A_W-1:0]        ahi5_ff, alo5_ff;
   logic [P_W-1:0]        mag5_in;

   assign mag5_in = in_p[P_W-1] ? P_W'(-in_p) : P_W'(in_p);

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else v5_ff <= in_valid;
      c5_ff.last <= in_tag.last;
      c5_ff.err  <= in_tag.err;
      c5_ff.zero <= 1'b0;
      c5_ff.neg  <= in_p[P_W-1];
      c5_ff.mag  <= mag5_in[MAG_W-1:0];
      big5_ff    <= (in_r2[R2_W-1:40] != '0) && (in_alpha != '0);
      ahi5_ff    <= A_W'(in_alpha) * A_W'(in_r2[39:20]);
      alo5_ff    <= A_W'(in_alpha) * A_W'(in_r2[19:0]);
   end

   logic            v6_ff;
   carry_type       c6_ff, c6_in;
   logic [Y_W-1:0]  y6_ff;
   logic [S_W-1:0]  sum6_in;

   assign sum6_in = S_W'({ahi5_ff, 20'd0}) + S_W'(alo5_ff);

   always_comb begin
      c6_in      = c5_ff;
      c6_in.zero = big5_ff || (sum6_in[S_W-1:40] != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else v6_ff <= v5_ff;
      c6_ff      <= c6_in;
      y6_ff      <= {sum6_in[39:20], 9'd0};
   end

   assign out_valid = v6_ff;
   assign out_carry = c6_ff;
   assign out_y     = y6_ff;

endmodule

FILE: rtl/core/goge_series.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// goge_series
// exp(-e) in Q30: ten Taylor terms, two stages each, then five squarings.
// ----------------------------------------------------------------------------
module goge_series (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  goge_pkg::carry_type           in_carry,
   input  logic [goge_pkg::Y_W-1:0]      in_y,
   output logic                          out_valid,
   output goge_pkg::carry_type           out_carry,
   output logic [goge_pkg::EX_W-1:0]     out_ex
);
   import goge_pkg::*;

   localparam int TY_W = TERM_W + Y_W;
   localparam int PR_W = TY_W - 30;
   localparam int QM_W = PR_W + 31;
   localparam logic [TERM_W-1:0] ONE_Q30 = TERM_W'(1) << 30;

   logic               av_ff [1:NTERMS];
   carry_type          ac_ff [1:NTERMS];
   logic [PR_W-1:0]    ap_ff [1:NTERMS];
   logic [Y_W-1:0]     ay_ff [1:NTERMS];
   logic signed [31:0] as_ff [1:NTERMS];
   logic               bv_ff [1:NTERMS];
   carry_type          bc_ff [1:NTERMS];
   logic [TERM_W-1:0]  bt_ff [1:NTERMS];
   logic [Y_W-1:0]     by_ff [1:NTERMS];
   logic signed [31:0] bs_ff [1:NTERMS];

   for (genvar n = 1; n <= NTERMS; n++) begin : g_term
      logic               v_in;
      carry_type          c_in;
      logic [TERM_W-1:0]  t_in;
      logic [Y_W-1:0]     y_in;
      logic signed [31:0] s_in;
      logic [TY_W-1:0]    ty_in;
      logic [QM_W-1:0]    qm_in;
      logic [TERM_W-1:0]  q_in;

      if (n == 1) begin : g_first
         assign v_in = in_valid;
         assign c_in = in_carry;
         assign t_in = ONE_Q30;
         assign y_in = in_y;
         assign s_in = 32'(ONE_Q30);
      end else begin : g_next
         assign v_in = bv_ff[n-1];
         assign c_in = bc_ff[n-1];
         assign t_in = bt_ff[n-1];
         assign y_in = by_ff[n-1];
         assign s_in = bs_ff[n-1];
      end

      assign ty_in = TY_W'(t_in) * TY_W'(y_in);
      assign qm_in = QM_W'(ap_ff[n]) * QM_W'(DIV_MAGIC[n]);
      assign q_in  = TERM_W'(qm_in >> DIV_SHIFT[n]);

      always_ff @(posedge clock) begin
         if (reset) av_ff[n] <= 1'b0;
         else av_ff[n] <= v_in;
         ac_ff[n] <= c_in;
         ap_ff[n] <= ty_in[TY_W-1:30];
         ay_ff[n] <= y_in;
         as_ff[n] <= s_in;
      end

      always_ff @(posedge clock) begin
         if (reset) bv_ff[n] <= 1'b0;
         else bv_ff[n] <= av_ff[n];
         bc_ff[n] <= ac_ff[n];
         bt_ff[n] <= q_in;
         by_ff[n] <= ay_ff[n];
         if (n % 2 == 1) bs_ff[n] <= as_ff[n] - 32'(q_in);
         else bs_ff[n] <= as_ff[n] + 32'(q_in);
      end
   end

   localparam logic [2*EX_W-1:0] HALF_Q30 = (2*EX_W)'(1) << 29;

   logic              sv_ff [1:NSQUARE];
   carry_type         sc_ff [1:NSQUARE];
   logic [EX_W-1:0]   se_ff [1:NSQUARE];

   for (genvar s = 1; s <= NSQUARE; s++) begin : g_square
      logic              v_in;
      carry_type         c_in;
      logic [EX_W-1:0]   e_in;
      logic [2*EX_W-1:0] ee_in;

      if (s == 1) begin : g_first
         assign v_in = bv_ff[NTERMS];
         assign c_in = bc_ff[NTERMS];
         assign e_in = bs_ff[NTERMS][EX_W-1:0];
      end else begin : g_next
         assign v_in = sv_ff[s-1];
         assign c_in = sc_ff[s-1];
         assign e_in = se_ff[s-1];
      end

      assign ee_in = (2*EX_W)'(e_in) * (2*EX_W)'(e_in) + HALF_Q30;

      always_ff @(posedge clock) begin
         if (reset) sv_ff[s] <= 1'b0;
         else sv_ff[s] <= v_in;
         sc_ff[s] <= c_in;
         se_ff[s] <= ee_in[EX_W+29:30];
      end
   end

   assign out_valid = sv_ff[NSQUARE];
   assign out_carry = sc_ff[NSQUARE];
   assign out_ex    = sc_ff[NSQUARE].zero ? '0 : se_ff[NSQUARE];

endmodule

FILE: rtl/core/goge_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// goge_scale
// Polynomial magnitude times exponential, rounding, sign and saturation.
// ----------------------------------------------------------------------------
module goge_scale (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  goge_pkg::carry_type                  in_carry,
   input  logic [goge_pkg::EX_W-1:0]            in_ex,
   output logic                                 out_strobe,
   output logic signed [goge_pkg::VALUE_W-1:0]  out_value,
   output logic                                 out_err,
   output logic                                 out_last
);
   import goge_pkg::*;

   localparam int HALF = MAG_W / 2;
   localparam int A_W  = HALF + EX_W;
   localparam int B_W  = A_W + 1;
   localparam int Q_W  = P_W;

   logic            va_ff;
   carry_type       ca_ff;
   logic [A_W-1:0]  a_ff;
   logic [B_W-1:0]  b_ff;

   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else va_ff <= in_valid;
      ca_ff <= in_carry;
      a_ff  <= A_W'(in_carry.mag[MAG_W-1:HALF]) * A_W'(in_ex);
      b_ff  <= B_W'(in_carry.mag[HALF-1:0]) * B_W'(in_ex) + (B_W'(1) << 29);
   end

   logic            vb_ff;
   carry_type       cb_ff;
   logic [Q_W-1:0]  q_ff;
   logic [B_W-1:0]  lo_in;

   assign lo_in = B_W'({a_ff[5:0], 24'd0}) + b_ff;

   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else vb_ff <= va_ff;
      cb_ff <= ca_ff;
      q_ff  <= Q_W'(a_ff >> 6) + Q_W'(lo_in >> 30);
   end

   logic                      vc_ff;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic                      err_ff, last_ff;

   always_comb begin
      priority if (cb_ff.err) val_in = '0;
      else if (cb_ff.neg)
         val_in = (q_ff > Q_W'(33'h100000000 >> 1)) ? {1'b1, {(VALUE_W-1){1'b0}}}
                                                    : -q_ff[VALUE_W-1:0];
      else
         val_in = (q_ff > Q_W'(32'h7FFFFFFF)) ? {1'b0, {(VALUE_W-1){1'b1}}}
                                              : q_ff[VALUE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else vc_ff <= vb_ff;
      val_ff  <= val_in;
      err_ff  <= cb_ff.err;
      last_ff <= cb_ff.last;
   end

   assign out_strobe = vc_ff;
   assign out_value  = val_ff;
   assign out_err    = err_ff;
   assign out_last   = last_ff;

endmodule

FILE: rtl/core/gaussian_orbital_grid_eval_core.sv
`timescale 1ns / 1ps
// A request passes the geom, expo, series and scale register stages before its result strobe.
// Throughput: one request per cycle; busy stays low, a request may come at every edge.
// Depth is set by the ten two-stage Taylor terms and five squaring stages of exp.
// Reset clears all pipeline valid bits and loads register defaults (inverse_radius 1.0).
// The receiver cannot stall; each result strobes for exactly one cycle.
// ----------------------------------------------------------------------------
// gaussian_orbital_grid_eval_core
// Gaussian type orbital value at one grid point per request, Q15.16.
// ----------------------------------------------------------------------------
module gaussian_orbital_grid_eval_core #(
   parameter int GRID_DIM = goge_pkg::GRID_DIM_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [goge_pkg::GRID_W-1:0]          req_grid_x,
   input  logic [goge_pkg::GRID_W-1:0]          req_grid_y,
   input  logic [goge_pkg::GRID_W-1:0]          req_grid_z,
   input  logic [goge_pkg::CNT_W-1:0]           req_orbital_count,
   input  logic [goge_pkg::CNT_W-1:0]           req_orbital_slot,
   input  logic                                 req_last_point,
   output logic                                 rsp_strobe,
   output logic signed [goge_pkg::VALUE_W-1:0]  rsp_orbital_value,
   output logic                                 rsp_kind_error,
   output logic                                 rsp_last_value,
   input  logic                                 csr_we,
   input  logic [goge_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [goge_pkg::CSR_W-1:0]           csr_wdata
);
   import goge_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{'0, '0, '0, '0, '0, '0, INV_RADIUS_RESET};
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SPACING_X:  cfg_ff.spacing_x  <= csr_wdata[SPACE_W-1:0];
            CSR_SPACING_Y:  cfg_ff.spacing_y  <= csr_wdata[SPACE_W-1:0];
            CSR_SPACING_Z:  cfg_ff.spacing_z  <= csr_wdata[SPACE_W-1:0];
            CSR_CENTER_X:   cfg_ff.center_x   <= $signed(csr_wdata[COORD_W-1:0]);
            CSR_CENTER_Y:   cfg_ff.center_y   <= $signed(csr_wdata[COORD_W-1:0]);
            CSR_CENTER_Z:   cfg_ff.center_z   <= $signed(csr_wdata[COORD_W-1:0]);
            CSR_INV_RADIUS: cfg_ff.inv_radius <= csr_wdata[INVR_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic                  g_valid;
   tag_type               g_tag;
   logic [R2_W-1:0]       g_r2;
   logic [ALPHA_W-1:0]    g_alpha;
   logic signed [P_W-1:0] g_p;

   goge_geom #(.GRID_DIM(GRID_DIM)) u_geom (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (start && !busy),
      .grid_x        (req_grid_x),
      .grid_y        (req_grid_y),
      .grid_z        (req_grid_z),
      .orbital_count (req_orbital_count),
      .orbital_slot  (req_orbital_slot),
      .last_point    (req_last_point),
      .out_valid     (g_valid),
      .out_tag       (g_tag),
      .out_r2        (g_r2),
      .out_alpha     (g_alpha),
      .out_p         (g_p)
   );

   logic            e_valid;
   carry_type       e_carry;
   logic [Y_W-1:0]  e_y;

   goge_expo u_expo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (g_valid),
      .in_tag    (g_tag),
      .in_r2     (g_r2),
      .in_alpha  (g_alpha),
      .in_p      (g_p),
      .out_valid (e_valid),
      .out_carry (e_carry),
      .out_y     (e_y)
   );

   logic             s_valid;
   carry_type        s_carry;
   logic [EX_W-1:0]  s_ex;

   goge_series u_series (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e_valid),
      .in_carry  (e_carry),
      .in_y      (e_y),
      .out_valid (s_valid),
      .out_carry (s_carry),
      .out_ex    (s_ex)
   );

   goge_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s_valid),
      .in_carry   (s_carry),
      .in_ex      (s_ex),
      .out_strobe (rsp_strobe),
      .out_value  (rsp_orbital_value),
      .out_err    (rsp_kind_error),
      .out_last   (rsp_last_value)
   );

`ifndef SYNTHESIS
   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LATENCY))
      else $error("result without request");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_kind_error) |-> (rsp_orbital_value == '0))
      else $error("kind error with nonzero value");
   a_last_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_last_value == $past(req_last_point, LATENCY)))
      else $error("last mark out of step");
`endif

endmodule
